/* hw/rtl/mcbf_pkg.sv */
// mcbf_pkg: shared constants, codes and types for the multi-category Bloom filter.
// No dependencies; used by every module under hw/rtl.
`default_nettype none
package mcbf_pkg;

  // parameter defaults
  localparam int FILTER_BITS_DEF = 262144;
  localparam int NUM_FILTERS_DEF = 9;
  localparam int NUM_PROBES_DEF  = 5;

  // search order register layout
  localparam int ORDER_SLOTS = 9;
  localparam int SLOT_W      = 4;
  localparam int ORDER_W     = ORDER_SLOTS * SLOT_W;
  localparam logic [ORDER_W-1:0] ORDER_RESET = 36'h806543271;

  localparam int BASE_W = 16;
  localparam logic [BASE_W-1:0] BASE_RESET = 16'd800;
  localparam int ID_W   = 17;

  // register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_ORDER  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_CATEGORY_BASE = 1'b1;

  // probe words: little-endian 32-bit, every third byte
  localparam int DIGEST_W     = 128;
  localparam int PROBE_W      = 32;
  localparam int PROBE_STRIDE = 24;

  // filter memory word
  localparam int WORD_BITS = 64;
  localparam int WORD_LOG  = 6;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_QUERY  = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_t;

endpackage
`default_nettype wire

/* hw/rtl/mcbf_mod_unit.sv */
// mcbf_mod_unit: reduces a 32-bit probe word modulo FILTER_BITS.
// Power-of-two sizes are masked directly; others use a reciprocal multiply,
// a multiply-subtract and one correction step, each registered. Depends on mcbf_pkg.
`default_nettype none
module mcbf_mod_unit #(
  parameter int FILTER_BITS = mcbf_pkg::FILTER_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  input  wire logic [mcbf_pkg::PROBE_W-1:0]   din,
  output logic                                done,
  output logic [$clog2(FILTER_BITS)-1:0]      rem
);
  localparam int  IDX_W   = $clog2(FILTER_BITS);
  localparam bit  IS_POW2 = (FILTER_BITS & (FILTER_BITS - 1)) == 0;
  // quotient estimate floor(x * M / 2^(31+IDX_W)) with M = floor(2^(31+IDX_W) / size)
  // is at most one low, so a single compare and subtract gives the remainder
  localparam logic [31:0] MAGIC = 32'((64'd1 << (31 + IDX_W)) / 64'(FILTER_BITS));
  localparam int  Q_W     = 33 - IDX_W;
  localparam int  D_W     = mcbf_pkg::PROBE_W + 2;

  logic                          v1_r, v2_r, v3_r;
  logic                          done_r;
  logic [mcbf_pkg::PROBE_W-1:0]  x_r;
  logic [Q_W-1:0]                q_r;
  logic [IDX_W:0]                d_r;
  logic [IDX_W-1:0]              r_r;
  logic [63:0]                   prod;
  logic [D_W-1:0]                diff;
  logic [IDX_W:0]                d_sub;
  logic [IDX_W-1:0]              r_nxt;

  assign prod  = 64'(x_r) * 64'(MAGIC);
  assign diff  = D_W'(x_r) - D_W'(q_r) * D_W'(FILTER_BITS);
  assign d_sub = d_r - (IDX_W+1)'(FILTER_BITS);
  assign r_nxt = (d_r >= (IDX_W+1)'(FILTER_BITS)) ? d_sub[IDX_W-1:0] : d_r[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      v3_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      v1_r   <= start && !IS_POW2;
      v2_r   <= v1_r;
      v3_r   <= v2_r;
      done_r <= (start && IS_POW2) || v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r <= din;
    end
    if (v1_r) begin
      q_r <= prod[31 + IDX_W +: Q_W];
    end
    if (v2_r) begin
      d_r <= diff[IDX_W:0];
    end
    if (start && IS_POW2) begin
      r_r <= din[IDX_W-1:0];
    end else if (v3_r) begin
      r_r <= r_nxt;
    end
  end

  assign done = done_r;
  assign rem  = r_r;

endmodule
`default_nettype wire

/* hw/rtl/mcbf_bit_mem.sv */
// mcbf_bit_mem: filter bit storage, one write and one read port, registered read.
// Word width from mcbf_pkg.
`default_nettype none
module mcbf_bit_mem #(
  parameter int DEPTH = 36864,
  parameter int AW    = 16
) (
  input  wire logic                             clk,
  input  wire logic                             we,
  input  wire logic [AW-1:0]                    waddr,
  input  wire logic [mcbf_pkg::WORD_BITS-1:0]   wdata,
  input  wire logic                             re,
  input  wire logic [AW-1:0]                    raddr,
  output logic      [mcbf_pkg::WORD_BITS-1:0]   rdata
);
  logic [mcbf_pkg::WORD_BITS-1:0] mem [DEPTH];
  logic [mcbf_pkg::WORD_BITS-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

/* hw/rtl/multi_category_bloom_filter.sv */
// multi_category_bloom_filter: top level, command sequencer and result register.
// Uses mcbf_pkg, mcbf_mod_unit and mcbf_bit_mem.
//
//  channel | ports                          | contents
//  --------+--------------------------------+-----------------------------------------
//  in      | in_tvalid/in_tready/in_tdata/  | tuser: command, category
//          | in_tuser                       | tdata: digest_lo, digest_hi
//  out     | out_tvalid/out_tready/out_tdata| tdata: found, found_filter, reported_id
//  cfg     | cfg_we/cfg_index/cfg_wdata     | 0 search_order, 1 category_base
//
// Sequencing: one item at a time. Each probe is reduced by the modulo unit. Insert then
//   does a read and a write back per probe on the bit memory. Query visits the search
//   slots in order and reads the probes of each filter tested, one read per cycle,
//   stopping at the first clear bit, then loads the result register.
// Reset and clear: the bit memory is swept one 64-bit word a cycle until every word is
//   zero; in_tready stays low meanwhile.
// Stalls: a finished query waits only if the previous result has not been taken.
`default_nettype none
module multi_category_bloom_filter #(
  parameter int FILTER_BITS = mcbf_pkg::FILTER_BITS_DEF,
  parameter int NUM_FILTERS = mcbf_pkg::NUM_FILTERS_DEF,
  parameter int NUM_PROBES  = mcbf_pkg::NUM_PROBES_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  // input items
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [127:0] in_tdata,   // [63:0] digest_lo, [127:64] digest_hi
  input  wire logic [5:0]   in_tuser,   // [1:0] command, [5:2] category
  // result items
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [23:0]       out_tdata,  // [0] found, [4:1] found_filter,
                                        // [21:5] reported_id, [23:22] zero
  // configuration
  input  wire logic                            cfg_we,
  input  wire logic [mcbf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [mcbf_pkg::ORDER_W-1:0]    cfg_wdata
);
  localparam int IDX_W      = $clog2(FILTER_BITS);
  localparam int TOTAL_BITS = NUM_FILTERS * FILTER_BITS;
  localparam int BA_W       = ($clog2(TOTAL_BITS) > mcbf_pkg::WORD_LOG) ?
                              $clog2(TOTAL_BITS) : mcbf_pkg::WORD_LOG + 1;
  localparam int MEM_AW     = BA_W - mcbf_pkg::WORD_LOG;
  localparam int MEM_DEPTH  = (TOTAL_BITS + mcbf_pkg::WORD_BITS - 1) / mcbf_pkg::WORD_BITS;
  localparam int PC_W       = $clog2(NUM_PROBES + 1);
  localparam int PI_W       = (NUM_PROBES > 1) ? $clog2(NUM_PROBES) : 1;
  localparam int NSLOTS     = (NUM_FILTERS < mcbf_pkg::ORDER_SLOTS) ?
                              NUM_FILTERS : mcbf_pkg::ORDER_SLOTS;
  localparam int SC_W       = $clog2(NSLOTS + 1);
  localparam int FW         = mcbf_pkg::SLOT_W;

  typedef enum logic [3:0] {
    ST_CLR, ST_IDLE, ST_HASH, ST_HWAIT, ST_IRD, ST_IWR, ST_QSLOT, ST_QRD, ST_RESULT
  } state_t;

  // registers
  state_t                          state_r, state_nxt;
  mcbf_pkg::cmd_t                  cmd_r, cmd_nxt;
  logic [mcbf_pkg::DIGEST_W-1:0]   dig_r, dig_nxt;
  logic [BA_W-1:0]                 fbase_r, fbase_nxt;
  logic [FW-1:0]                   cur_f_r, cur_f_nxt;
  logic [PC_W-1:0]                 p_r, p_nxt;
  logic [SC_W-1:0]                 s_r, s_nxt;
  logic [MEM_AW-1:0]               clr_row_r, clr_row_nxt;
  logic                            rd_pend_r, rd_pend_nxt;
  logic                            rd_last_r, rd_last_nxt;
  logic [mcbf_pkg::WORD_LOG-1:0]   rd_bit_r, rd_bit_nxt;
  logic                            res_found_r, res_found_nxt;
  logic [IDX_W-1:0]                idx_r [NUM_PROBES];
  logic [mcbf_pkg::ORDER_W-1:0]    search_order_r;
  logic [mcbf_pkg::BASE_W-1:0]     category_base_r;
  logic                            out_valid_r, out_valid_nxt;
  logic                            out_found_r, out_found_nxt;
  logic [FW-1:0]                   out_ff_r, out_ff_nxt;
  logic [mcbf_pkg::ID_W-1:0]       out_id_r, out_id_nxt;

  // datapath
  logic                            idx_we;
  logic                            mod_start;
  logic                            mod_done;
  logic [IDX_W-1:0]                mod_rem;
  logic [mcbf_pkg::PROBE_W-1:0]    probe_word;
  logic [BA_W-1:0]                 bit_addr;
  logic [MEM_AW-1:0]               row;
  logic [mcbf_pkg::WORD_LOG-1:0]   bitpos;
  logic [FW-1:0]                   slot_f;
  logic                            hit;
  logic                            mem_we, mem_re;
  logic [MEM_AW-1:0]               mem_waddr, mem_raddr;
  logic [mcbf_pkg::WORD_BITS-1:0]  mem_wdata, mem_rdata;
  logic                            in_fire;
  mcbf_pkg::cmd_t                  in_cmd;
  logic [FW-1:0]                   in_cat;

  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign in_cmd    = mcbf_pkg::cmd_t'(in_tuser[1:0]);
  assign in_cat    = in_tuser[5:2];

  // probe p is the 32-bit word at byte offset 3p
  assign probe_word = dig_r[mcbf_pkg::PROBE_STRIDE * int'(p_r) +: mcbf_pkg::PROBE_W];

  // bit address within the flat memory: filter base plus probe index
  assign bit_addr = fbase_r + BA_W'(idx_r[p_r[PI_W-1:0]]);
  assign row      = bit_addr[mcbf_pkg::WORD_LOG +: MEM_AW];
  assign bitpos   = bit_addr[mcbf_pkg::WORD_LOG-1:0];
  assign slot_f   = search_order_r[FW * int'(s_r) +: FW];
  assign hit      = mem_rdata[rd_bit_r];

  mcbf_mod_unit #(
    .FILTER_BITS(FILTER_BITS)
  ) u_mod (
    .clk  (clk),
    .rst_n(rst_n),
    .start(mod_start),
    .din  (probe_word),
    .done (mod_done),
    .rem  (mod_rem)
  );

  mcbf_bit_mem #(
    .DEPTH(MEM_DEPTH),
    .AW   (MEM_AW)
  ) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    dig_nxt       = dig_r;
    fbase_nxt     = fbase_r;
    cur_f_nxt     = cur_f_r;
    p_nxt         = p_r;
    s_nxt         = s_r;
    clr_row_nxt   = clr_row_r;
    rd_pend_nxt   = 1'b0;
    rd_last_nxt   = rd_last_r;
    rd_bit_nxt    = rd_bit_r;
    res_found_nxt = res_found_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_found_nxt = out_found_r;
    out_ff_nxt    = out_ff_r;
    out_id_nxt    = out_id_r;
    idx_we        = 1'b0;
    mod_start     = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = row;
    mem_wdata     = mem_rdata | (mcbf_pkg::WORD_BITS'(1) << bitpos);
    mem_re        = 1'b0;
    mem_raddr     = row;

    case (state_r)
      ST_CLR: begin
        // zero one word per cycle
        mem_we    = 1'b1;
        mem_waddr = clr_row_r;
        mem_wdata = '0;
        if (clr_row_r == MEM_AW'(MEM_DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end else begin
          clr_row_nxt = clr_row_r + 1'b1;
        end
      end

      ST_IDLE: begin
        if (in_fire) begin
          cmd_nxt   = in_cmd;
          dig_nxt   = in_tdata;
          p_nxt     = '0;
          fbase_nxt = BA_W'(in_cat) * BA_W'(FILTER_BITS);
          case (in_cmd)
            mcbf_pkg::CMD_INSERT: begin
              // an insert into a missing filter changes nothing
              if (32'(in_cat) < NUM_FILTERS) begin
                state_nxt = ST_HASH;
              end
            end
            mcbf_pkg::CMD_QUERY: state_nxt = ST_HASH;
            mcbf_pkg::CMD_CLEAR: begin
              clr_row_nxt = '0;
              state_nxt   = ST_CLR;
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end

      ST_HASH: begin
        mod_start = 1'b1;
        state_nxt = ST_HWAIT;
      end

      ST_HWAIT: begin
        if (mod_done) begin
          idx_we = 1'b1;
          if (p_r == PC_W'(NUM_PROBES - 1)) begin
            p_nxt = '0;
            if (cmd_r == mcbf_pkg::CMD_INSERT) begin
              state_nxt = ST_IRD;
            end else begin
              s_nxt     = '0;
              state_nxt = ST_QSLOT;
            end
          end else begin
            p_nxt     = p_r + 1'b1;
            state_nxt = ST_HASH;
          end
        end
      end

      ST_IRD: begin
        mem_re    = 1'b1;
        state_nxt = ST_IWR;
      end

      ST_IWR: begin
        // read data is current: the previous write landed before this read
        mem_we = 1'b1;
        if (p_r == PC_W'(NUM_PROBES - 1)) begin
          state_nxt = ST_IDLE;
        end else begin
          p_nxt     = p_r + 1'b1;
          state_nxt = ST_IRD;
        end
      end

      ST_QSLOT: begin
        if (s_r == SC_W'(NSLOTS)) begin
          res_found_nxt = 1'b0;
          state_nxt     = ST_RESULT;
        end else if (32'(slot_f) < NUM_FILTERS) begin
          cur_f_nxt = slot_f;
          fbase_nxt = BA_W'(slot_f) * BA_W'(FILTER_BITS);
          p_nxt     = '0;
          state_nxt = ST_QRD;
        end else begin
          // slot names a missing filter
          s_nxt = s_r + 1'b1;
        end
      end

      ST_QRD: begin
        // one probe read issued per cycle, checked the next cycle
        if (rd_pend_r && !hit) begin
          s_nxt     = s_r + 1'b1;
          state_nxt = ST_QSLOT;
        end else if (rd_pend_r && rd_last_r) begin
          res_found_nxt = 1'b1;
          state_nxt     = ST_RESULT;
        end else if (p_r < PC_W'(NUM_PROBES)) begin
          mem_re      = 1'b1;
          rd_pend_nxt = 1'b1;
          rd_bit_nxt  = bitpos;
          rd_last_nxt = (p_r == PC_W'(NUM_PROBES - 1));
          p_nxt       = p_r + 1'b1;
        end
      end

      ST_RESULT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = res_found_r;
          out_ff_nxt    = res_found_r ? cur_f_r : '0;
          out_id_nxt    = res_found_r ?
                          mcbf_pkg::ID_W'(category_base_r) + mcbf_pkg::ID_W'(cur_f_r) : '0;
          state_nxt     = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_CLR;
      clr_row_r       <= '0;
      rd_pend_r       <= 1'b0;
      out_valid_r     <= 1'b0;
      search_order_r  <= mcbf_pkg::ORDER_RESET;
      category_base_r <= mcbf_pkg::BASE_RESET;
    end else begin
      state_r     <= state_nxt;
      clr_row_r   <= clr_row_nxt;
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          mcbf_pkg::CFG_SEARCH_ORDER:  search_order_r  <= cfg_wdata;
          mcbf_pkg::CFG_CATEGORY_BASE: category_base_r <= cfg_wdata[mcbf_pkg::BASE_W-1:0];
          default: ;
        endcase
      end
    end
    cmd_r       <= cmd_nxt;
    dig_r       <= dig_nxt;
    fbase_r     <= fbase_nxt;
    cur_f_r     <= cur_f_nxt;
    p_r         <= p_nxt;
    s_r         <= s_nxt;
    rd_last_r   <= rd_last_nxt;
    rd_bit_r    <= rd_bit_nxt;
    res_found_r <= res_found_nxt;
    out_found_r <= out_found_nxt;
    out_ff_r    <= out_ff_nxt;
    out_id_r    <= out_id_nxt;
    if (idx_we) begin
      idx_r[p_r[PI_W-1:0]] <= mod_rem;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_id_r, out_ff_r, out_found_r};

`ifndef SYNTHESIS
  // a new result only comes from the result state
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_RESULT))
    else $error("result appeared outside the result state");

  // queries never write the filters
  a_query_ro: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_QRD || state_r == ST_QSLOT) |-> !mem_we)
    else $error("memory write during a query");

  // a reported filter exists, and a miss reports zeros
  a_found_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_found_r) |-> (32'(out_ff_r) < NUM_FILTERS))
    else $error("found filter out of range");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_found_r) |-> (out_ff_r == '0 && out_id_r == '0))
    else $error("miss result carries nonzero fields");

  // the clearing sweep writes zeros every cycle and blocks input
  a_clear_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLR) |-> (mem_we && mem_wdata == '0 && !in_tready))
    else $error("clear sweep broken");
`endif

endmodule
`default_nettype wire
